>>> rtl/tsam_pkg.sv
// shared constants, types and register codes for the touch sample average and map block
`timescale 1ns / 1ps
`default_nettype none

package tsam_pkg;

  // pairs averaged into one touch point
  localparam int SAMPLES = 3;

  // field widths
  localparam int RAW_W   = 12;
  localparam int COORD_W = 12;
  localparam int SIZE_W  = 13;
  localparam int TDATA_W = ((2 * RAW_W + 7) / 8) * 8;

  // running sum and pair counter
  localparam int SUM_W = $clog2(SAMPLES * ((1 << RAW_W) - 1) + 1);
  localparam int CNT_W = $clog2(SAMPLES + 1);

  // division of the sum by SAMPLES as a multiply by a rounded-up reciprocal
  localparam int          DIV_L       = $clog2(SAMPLES);
  localparam int          RECIP_SHIFT = SUM_W + DIV_L;
  localparam int unsigned RECIP       = ((1 << RECIP_SHIFT) + SAMPLES - 1) / SAMPLES;
  localparam int          RECIP_W     = RECIP_SHIFT + 1;
  localparam int          AVG_MUL_W   = SUM_W + RECIP_W;

  // mapping product and its sequential division
  localparam int PROD_W    = RAW_W + SIZE_W;
  localparam int DIV_CNT_W = $clog2(PROD_W + 1);

  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN         = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX         = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN         = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX         = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(5);

  // calibration defaults
  localparam logic [RAW_W-1:0]  X_MIN_RST         = RAW_W'(350);
  localparam logic [RAW_W-1:0]  X_MAX_RST         = RAW_W'(3900);
  localparam logic [RAW_W-1:0]  Y_MIN_RST         = RAW_W'(350);
  localparam logic [RAW_W-1:0]  Y_MAX_RST         = RAW_W'(3800);
  localparam logic [SIZE_W-1:0] SCREEN_WIDTH_RST  = SIZE_W'(480);
  localparam logic [SIZE_W-1:0] SCREEN_HEIGHT_RST = SIZE_W'(320);

  // one job handed from front to back
  typedef struct packed {
    logic             pressed;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
  } job_t;

  // calibration register set
  typedef struct packed {
    logic [RAW_W-1:0]  x_min;
    logic [RAW_W-1:0]  x_max;
    logic [RAW_W-1:0]  y_min;
    logic [RAW_W-1:0]  y_max;
    logic [SIZE_W-1:0] screen_width;
    logic [SIZE_W-1:0] screen_height;
  } cal_t;

  // queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/tsam_fifo.sv
// two-entry job queue between the sample front end and the mapping back end
`timescale 1ns / 1ps
`default_nettype none

module tsam_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  tsam_pkg::job_t       push_job,
  input  wire                  pop,
  output tsam_pkg::job_t       head_job,
  output tsam_pkg::fifo_stat_t stat
);

  tsam_pkg::job_t                    mem_r [tsam_pkg::FIFO_DEPTH];
  logic [tsam_pkg::FIFO_AW-1:0]      wr_ptr_r;
  logic [tsam_pkg::FIFO_AW-1:0]      rd_ptr_r;
  logic [tsam_pkg::FIFO_CW-1:0]      count_r;
  logic                              do_push;
  logic                              do_pop;

  // status and head of queue
  assign stat.full  = (count_r == tsam_pkg::FIFO_CW'(tsam_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

`default_nettype wire

>>> rtl/tsam_front.sv
// front end: takes sample pairs, sums each burst and queues finished or pen-up jobs
`timescale 1ns / 1ps
`default_nettype none

module tsam_front (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [tsam_pkg::TDATA_W-1:0]        in_tdata,  // raw_x, raw_y
  input  wire                                 in_tuser,  // pen_down
  output logic                                push_valid,
  output tsam_pkg::job_t                      push_job,
  input  tsam_pkg::fifo_stat_t                fifo_stat
);

  logic [tsam_pkg::SUM_W-1:0] sum_x_r;
  logic [tsam_pkg::SUM_W-1:0] sum_y_r;
  logic [tsam_pkg::CNT_W-1:0] cnt_r;
  logic [tsam_pkg::SUM_W-1:0] sum_x_nxt;
  logic [tsam_pkg::SUM_W-1:0] sum_y_nxt;
  logic [tsam_pkg::RAW_W-1:0] raw_x;
  logic [tsam_pkg::RAW_W-1:0] raw_y;
  logic                       accept;
  logic                       last_pair;

  // field split and accept
  assign raw_x     = in_tdata[tsam_pkg::RAW_W-1:0];
  assign raw_y     = in_tdata[2*tsam_pkg::RAW_W-1:tsam_pkg::RAW_W];
  assign in_tready = !fifo_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign last_pair = (cnt_r == tsam_pkg::CNT_W'(tsam_pkg::SAMPLES - 1));

  // running sums with this pair added
  assign sum_x_nxt = sum_x_r + tsam_pkg::SUM_W'(raw_x);
  assign sum_y_nxt = sum_y_r + tsam_pkg::SUM_W'(raw_y);

  // a job leaves on pen up or on the last pair of a burst
  always_comb begin
    push_valid       = accept && (!in_tuser || last_pair);
    push_job.pressed = in_tuser;
    push_job.sum_x   = in_tuser ? sum_x_nxt : '0;
    push_job.sum_y   = in_tuser ? sum_y_nxt : '0;
  end

  // burst accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      if (!in_tuser || last_pair) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
        cnt_r   <= '0;
      end else begin
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
        cnt_r   <= cnt_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tsam_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module tsam_div (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  input  wire  [tsam_pkg::PROD_W-1:0]        dividend,
  input  wire  [tsam_pkg::RAW_W-1:0]         divisor,
  output logic [tsam_pkg::PROD_W-1:0]        quotient,
  output tsam_pkg::div_stat_t                stat
);

  logic [tsam_pkg::PROD_W-1:0]    quo_r;
  logic [tsam_pkg::RAW_W-1:0]     rem_r;
  logic [tsam_pkg::RAW_W-1:0]     den_r;
  logic [tsam_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [tsam_pkg::RAW_W:0]       rem_sh;
  logic [tsam_pkg::RAW_W:0]       trial;
  logic                           fits;

  // one trial subtraction
  assign rem_sh = {rem_r, quo_r[tsam_pkg::PROD_W-1]};
  assign trial  = rem_sh - {1'b0, den_r};
  assign fits   = (rem_sh >= {1'b0, den_r});

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tsam_pkg::DIV_CNT_W'(tsam_pkg::PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[tsam_pkg::PROD_W-2:0], fits};
      rem_r <= fits ? trial[tsam_pkg::RAW_W-1:0] : rem_sh[tsam_pkg::RAW_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/tsam_back.sv
// back end: averages a burst, clamps, scales and divides per axis, holds the result; pen-up jobs give zero
`timescale 1ns / 1ps
`default_nettype none

module tsam_back (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  tsam_pkg::fifo_stat_t                fifo_stat,
  input  tsam_pkg::job_t                      head_job,
  output logic                                pop,
  input  tsam_pkg::cal_t                      cal,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [tsam_pkg::TDATA_W-1:0]        out_tdata,  // screen_x, screen_y
  output logic                                out_tuser   // pressed
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_CLAMP,
    ST_MUL,
    ST_GO,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // per axis lanes, x in lane 0 and y in lane 1
  logic [tsam_pkg::SUM_W-1:0]     sum_r      [2];
  logic [tsam_pkg::RAW_W-1:0]     avg_r      [2];
  logic [tsam_pkg::RAW_W-1:0]     diff_r     [2];
  logic [tsam_pkg::RAW_W-1:0]     den_r      [2];
  logic [tsam_pkg::SIZE_W-1:0]    span_r     [2];
  logic                           zero_r     [2];
  logic [tsam_pkg::PROD_W-1:0]    mul_r      [2];
  logic [tsam_pkg::COORD_W-1:0]   res_r      [2];
  logic                           pressed_r;

  logic [tsam_pkg::RAW_W-1:0]     lo         [2];
  logic [tsam_pkg::RAW_W-1:0]     hi         [2];
  logic [tsam_pkg::SIZE_W-1:0]    size       [2];
  logic [tsam_pkg::AVG_MUL_W-1:0] avg_prod   [2];
  logic [tsam_pkg::RAW_W-1:0]     avg_nxt    [2];
  logic [tsam_pkg::RAW_W-1:0]     clamp_v    [2];
  logic [tsam_pkg::RAW_W-1:0]     diff_nxt   [2];
  logic [tsam_pkg::RAW_W-1:0]     den_nxt    [2];
  logic [tsam_pkg::SIZE_W-1:0]    span_nxt   [2];
  logic                           zero_nxt   [2];
  logic [tsam_pkg::PROD_W-1:0]    mul_nxt    [2];
  logic [tsam_pkg::PROD_W-1:0]    quo        [2];
  logic [tsam_pkg::COORD_W-1:0]   res_nxt    [2];
  tsam_pkg::div_stat_t            div_stat   [2];

  logic                           out_valid_r;
  logic                           out_pressed_r;
  logic [tsam_pkg::COORD_W-1:0]   out_x_r;
  logic [tsam_pkg::COORD_W-1:0]   out_y_r;
  logic                           div_start;

  // calibration per lane
  always_comb begin
    lo[0]   = cal.x_min;
    hi[0]   = cal.x_max;
    size[0] = cal.screen_width;
    lo[1]   = cal.y_min;
    hi[1]   = cal.y_max;
    size[1] = cal.screen_height;
  end

  // lane datapath: average, clamp, scale, saturate
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      avg_prod[i] = tsam_pkg::AVG_MUL_W'(sum_r[i]) *
                    tsam_pkg::AVG_MUL_W'(tsam_pkg::RECIP);
      avg_nxt[i]  = avg_prod[i][tsam_pkg::RECIP_SHIFT +: tsam_pkg::RAW_W];

      zero_nxt[i] = (hi[i] <= lo[i]) || (size[i] == '0);
      clamp_v[i]  = avg_r[i];
      if (clamp_v[i] < lo[i]) clamp_v[i] = lo[i];
      if (clamp_v[i] > hi[i]) clamp_v[i] = hi[i];
      diff_nxt[i] = clamp_v[i] - lo[i];
      den_nxt[i]  = zero_nxt[i] ? tsam_pkg::RAW_W'(1) : (hi[i] - lo[i]);
      span_nxt[i] = size[i] - 1'b1;

      mul_nxt[i]  = tsam_pkg::PROD_W'(diff_r[i]) * tsam_pkg::PROD_W'(span_r[i]);

      if (zero_r[i]) begin
        res_nxt[i] = '0;
      end else if (|quo[i][tsam_pkg::PROD_W-1:tsam_pkg::COORD_W]) begin
        res_nxt[i] = tsam_pkg::COORD_MAX;
      end else begin
        res_nxt[i] = quo[i][tsam_pkg::COORD_W-1:0];
      end
    end
  end

  // one divider per axis
  assign div_start = (state_r == ST_GO);

  for (genvar g = 0; g < 2; g++) begin : g_div
    tsam_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (mul_r[g]),
      .divisor  (den_r[g]),
      .quotient (quo[g]),
      .stat     (div_stat[g])
    );
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!fifo_stat.empty) begin
          pop       = 1'b1;
          state_nxt = head_job.pressed ? ST_AVG : ST_DONE;
        end
      end
      ST_AVG:   state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_GO;
      ST_GO:    state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_stat[0].done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer state, lane registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // result valid: loaded when a job finishes, dropped once taken
      if ((state_r == ST_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (!fifo_stat.empty) begin
            pressed_r <= head_job.pressed;
            sum_r[0]  <= head_job.sum_x;
            sum_r[1]  <= head_job.sum_y;
            res_r[0]  <= '0;
            res_r[1]  <= '0;
          end
        end
        ST_AVG: begin
          avg_r[0] <= avg_nxt[0];
          avg_r[1] <= avg_nxt[1];
        end
        ST_CLAMP: begin
          for (int i = 0; i < 2; i++) begin
            diff_r[i] <= diff_nxt[i];
            den_r[i]  <= den_nxt[i];
            span_r[i] <= span_nxt[i];
            zero_r[i] <= zero_nxt[i];
          end
        end
        ST_MUL: begin
          mul_r[0] <= mul_nxt[0];
          mul_r[1] <= mul_nxt[1];
        end
        ST_DIV: begin
          if (div_stat[0].done) begin
            res_r[0] <= res_nxt[0];
            res_r[1] <= res_nxt[1];
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_pressed_r <= pressed_r;
            out_x_r       <= res_r[0];
            out_y_r       <= res_r[1];
          end
        end
        default: ;
      endcase
    end
  end

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_pressed_r;
  assign out_tdata  = tsam_pkg::TDATA_W'({out_y_r, out_x_r});

endmodule

`default_nettype wire

>>> rtl/touch_sample_average_map_top.sv
// Touch sample average and map: top level with calibration registers.
// A pen-up request goes from the queue straight to the result register; a burst-ending
// request is averaged, clamped, scaled and divided by the 25-step restoring dividers
// (one per axis). Throughput: a request is taken in each cycle while the two-entry job
// queue has room; jobs leave the queue one at a time.
// Reset (rst_n low, synchronous): sums, counters and queue cleared, calibration defaults.
`timescale 1ns / 1ps
`default_nettype none

module touch_sample_average_map_top (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // sample channel
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [tsam_pkg::TDATA_W-1:0]         in_tdata,   // raw_x [11:0], raw_y [23:12]
  input  wire                                  in_tuser,   // pen_down
  // result channel
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [tsam_pkg::TDATA_W-1:0]         out_tdata,  // screen_x [11:0], screen_y [23:12]
  output logic                                 out_tuser,  // pressed
  // calibration write channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [tsam_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [tsam_pkg::CFG_DATA_W-1:0]      cfg_data
);

  tsam_pkg::cal_t       cal_r;
  tsam_pkg::fifo_stat_t fifo_stat;
  tsam_pkg::job_t       push_job;
  tsam_pkg::job_t       head_job;
  logic                 push_valid;
  logic                 pop;

  // calibration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.x_min         <= tsam_pkg::X_MIN_RST;
      cal_r.x_max         <= tsam_pkg::X_MAX_RST;
      cal_r.y_min         <= tsam_pkg::Y_MIN_RST;
      cal_r.y_max         <= tsam_pkg::Y_MAX_RST;
      cal_r.screen_width  <= tsam_pkg::SCREEN_WIDTH_RST;
      cal_r.screen_height <= tsam_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsam_pkg::REG_X_MIN:         cal_r.x_min <= cfg_data[tsam_pkg::RAW_W-1:0];
        tsam_pkg::REG_X_MAX:         cal_r.x_max <= cfg_data[tsam_pkg::RAW_W-1:0];
        tsam_pkg::REG_Y_MIN:         cal_r.y_min <= cfg_data[tsam_pkg::RAW_W-1:0];
        tsam_pkg::REG_Y_MAX:         cal_r.y_max <= cfg_data[tsam_pkg::RAW_W-1:0];
        tsam_pkg::REG_SCREEN_WIDTH:  cal_r.screen_width <= cfg_data[tsam_pkg::SIZE_W-1:0];
        tsam_pkg::REG_SCREEN_HEIGHT: cal_r.screen_height <= cfg_data[tsam_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  tsam_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_job   (push_job),
    .fifo_stat  (fifo_stat)
  );

  // job queue
  tsam_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (fifo_stat)
  );

  // back end
  tsam_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .head_job   (head_job),
    .pop        (pop),
    .cal        (cal_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // a job is never offered to a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_valid && fifo_stat.full))
    else $error("job pushed into full queue");

  // a pen-up result carries zero coordinates
  a_penup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("pen-up result with nonzero coordinates");

  // an empty x calibration maps every pressed point to x zero
  a_empty_cal_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser && (cal_r.x_max <= cal_r.x_min))
      |-> (out_tdata[tsam_pkg::COORD_W-1:0] == '0))
    else $error("empty x calibration gave nonzero x");

endmodule

`default_nettype wire
